// ----- design/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the range frame parser and its top level.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam logic [7:0]  HDR_BYTE      = 8'hFF;
    localparam int          AGE_W         = 17;
    localparam logic [AGE_W-1:0] AGE_MAX  = {AGE_W{1'b1}};
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        POS_HUNT = 2'd0,
        POS_HIGH = 2'd1,
        POS_LOW  = 2'd2,
        POS_SUM  = 2'd3
    } pos_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [15:0] distance_mm;
        logic        distance_valid;
        logic        frame_accepted;
    } rsp_t;

endpackage

// ----- design/sfp_core.sv -----
// ----------------------------------------------------------------------------
// sfp_core
// Frame assembly, checksum test, age counter and timeout register.
// ----------------------------------------------------------------------------
module sfp_core
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  req_t        item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output rsp_t        result
);

    pos_t             pos_reg,     pos_next;
    logic [7:0]       high_reg,    high_next;
    logic [7:0]       low_reg,     low_next;
    logic [15:0]      dist_reg,    dist_next;
    logic             vld_reg,     vld_next;
    logic [AGE_W-1:0] age_reg,     age_next;
    logic [15:0]      timeout_reg;
    logic             frame_ok;

    always_comb
    begin
        pos_next  = pos_reg;
        high_next = high_reg;
        low_next  = low_reg;
        dist_next = dist_reg;
        vld_next  = vld_reg;
        age_next  = age_reg;
        frame_ok  = 1'b0;
        if (item.cmd == CMD_BYTE)
        begin
            unique case (pos_reg)
                POS_HUNT:
                begin
                    if (item.rx_byte == HDR_BYTE)
                        pos_next = POS_HIGH;
                end
                POS_HIGH:
                begin
                    high_next = item.rx_byte;
                    pos_next  = POS_LOW;
                end
                POS_LOW:
                begin
                    low_next = item.rx_byte;
                    pos_next = POS_SUM;
                end
                POS_SUM:
                begin
                    pos_next = POS_HUNT;
                    if (8'(HDR_BYTE + high_reg + low_reg) == item.rx_byte)
                    begin
                        frame_ok  = 1'b1;
                        dist_next = {high_reg, low_reg};
                        vld_next  = 1'b1;
                        age_next  = '0;
                    end
                end
                default: pos_next = POS_HUNT;
            endcase
        end
        else if (age_reg != AGE_MAX)
        begin
            age_next = age_reg + 1'b1;
        end
        if (age_next > {1'b0, timeout_reg})
            vld_next = 1'b0;
        result.distance_mm    = dist_next;
        result.distance_valid = vld_next;
        result.frame_accepted = frame_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_HUNT;
            high_reg    <= '0;
            low_reg     <= '0;
            dist_reg    <= '0;
            vld_reg     <= 1'b0;
            age_reg     <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (step)
            begin
                pos_reg  <= pos_next;
                high_reg <= high_next;
                low_reg  <= low_next;
                dist_reg <= dist_next;
                vld_reg  <= vld_next;
                age_reg  <= age_next;
            end
            if (cfg_we)
                timeout_reg <= cfg_data;
        end
    end

    a_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (step && frame_ok) |=> (vld_reg && age_reg == '0))
        else $error("good frame did not set valid and clear age");

    a_age_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.cmd == CMD_TICK && age_reg != AGE_MAX)
            |=> age_reg == AGE_W'($past(age_reg) + 1'b1))
        else $error("tick did not advance age");

    a_tick_keeps_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.cmd == CMD_TICK)
            |=> ($stable(pos_reg) && $stable(dist_reg) && $stable(high_reg)))
        else $error("tick disturbed frame state");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(pos_reg) && $stable(age_reg) && $stable(vld_reg)))
        else $error("state changed without a request");

endmodule

// ----- design/sonar_frame_parser_with_timeout_unit.sv -----
// ----------------------------------------------------------------------------
// sonar_frame_parser_with_timeout_unit
// Range sensor frame parser with staleness timeout, valid/stall channels.
// ----------------------------------------------------------------------------
// Each request is a received byte or a one millisecond tick and yields exactly
// one result carrying the current distance, its valid flag and a pulse for a
// frame completed with a good checksum. One request is taken every cycle while
// req_stall is low; a request is held in the input register and its result in
// the result register, and the parser state is updated between those registers.
// The timeout register is written through the cfg channel, which is always
// ready and must be used only while idle.
module sonar_frame_parser_with_timeout_unit
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic in_vld_reg;
    req_t in_reg;
    logic out_vld_reg;
    rsp_t out_reg;
    rsp_t result;
    logic out_open;
    logic step;

    assign out_open  = !out_vld_reg || !rsp_stall;
    assign step      = in_vld_reg && out_open;
    assign req_stall = in_vld_reg && !out_open;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    sfp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (in_reg),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
                in_vld_reg <= req_valid;
            if (out_open)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_reg <= req;
        if (step)
            out_reg <= result;
    end

endmodule
